### hdl/sacl_pkg.sv
// Shared types, constants and codes of the set-associative LRU cache tag store.
package sacl_pkg;

   localparam int MAX_SET_BITS = 6;
   localparam int MAX_WAYS     = 8;
   localparam int NUM_SETS     = 1 << MAX_SET_BITS;
   localparam int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WAYS_W       = $clog2(MAX_WAYS + 1);
   localparam int TAG_W        = 64;
   localparam int RANK_W       = 4;
   localparam int CNT_W        = 32;
   localparam int OFFSET_MAX   = 32;
   localparam int SBITS_W      = 3;
   localparam int OBITS_W      = 6;
   localparam int EBITS_W      = 4;
   localparam int CSR_DATA_W   = 6;
   localparam int CSR_IDX_W    = 2;
   localparam int SHIFT_W      = 7;
   localparam int TAG_ROW_W    = MAX_WAYS * TAG_W;
   localparam int META_ROW_W   = MAX_WAYS * (1 + RANK_W);

   localparam logic [RANK_W-1:0] RANK_MAX = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SET_BITS    = 2'd0,
      CSR_OFFSET_BITS = 2'd1,
      CSR_WAYS        = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      OUT_HIT   = 2'd0,
      OUT_FILL  = 2'd1,
      OUT_EVICT = 2'd2,
      OUT_NONE  = 2'd3
   } outcome_type;

   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_STORE  = 2'd1;
   localparam logic [1:0] KIND_MODIFY = 2'd2;
   localparam logic [1:0] KIND_SPARE  = 2'd3;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_UPDATE = 1'b1
   } state_type;

   typedef struct packed {
      logic accept;
      logic update;
   } cmd_type;

endpackage

### hdl/sacl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sacl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hdl/sacl_ctrl.sv
// Controller state machine: accept a word, then run the update state.
module sacl_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output sacl_pkg::cmd_type cmd
);
   import sacl_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b0;
      unique case (state_ff)
         ST_IDLE:   cmd.accept = start;
         ST_UPDATE: begin
            cmd.update = 1'b1;
            busy       = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/sacl_dpath.sv
// Datapath: config registers, tag and metadata RAMs, lookup, LRU update, totals.
module sacl_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  sacl_pkg::cmd_type                  cmd,
   input  logic [1:0]                         req_kind,
   input  logic [sacl_pkg::TAG_W-1:0]         req_address,
   input  logic                               csr_we,
   input  logic [sacl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sacl_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                               rsp_strobe,
   output logic [1:0]                         rsp_outcome,
   output logic [1:0]                         rsp_hits_added,
   output logic [2:0]                         rsp_way_used,
   output logic [5:0]                         rsp_set_index,
   output logic [sacl_pkg::CNT_W-1:0]         rsp_hit_total,
   output logic [sacl_pkg::CNT_W-1:0]         rsp_miss_total,
   output logic [sacl_pkg::CNT_W-1:0]         rsp_evict_total
);
   import sacl_pkg::*;

   logic [SBITS_W-1:0] sbits_ff;
   logic [OBITS_W-1:0] obits_ff;
   logic [EBITS_W-1:0] ebits_ff;

   logic [SBITS_W-1:0] s_eff;
   logic [OBITS_W-1:0] b_eff;
   logic [WAYS_W-1:0]  e_eff;
   logic [SET_W-1:0]   smask;
   logic [TAG_W-1:0]   addr_shifted;
   logic [SET_W-1:0]   set_calc;

   logic [1:0]         kind_ff;
   logic [TAG_W-1:0]   addr_ff;
   logic [SET_W-1:0]   set_ff;
   logic [NUM_SETS-1:0] rowv_ff;

   logic [TAG_ROW_W-1:0]  tag_rd, tag_wr;
   logic [META_ROW_W-1:0] meta_rd, meta_wr;
   logic [TAG_W-1:0]      tag_calc;

   logic [MAX_WAYS-1:0]   way_valid, way_on;
   logic [RANK_W-1:0]     way_rank [MAX_WAYS];
   logic                  hit, cold;
   logic [WAY_W-1:0]      hit_way, cold_way, vic_way, fill_way, way_sel;
   logic                  vic_found;
   logic [RANK_W-1:0]     hit_rank;
   logic [1:0]            added;
   logic [1:0]            outcome;
   logic [CNT_W:0]        hit_sum, miss_sum, evict_sum;

   logic                  strobe_ff;
   logic [1:0]            outcome_ff, added_ff;
   logic [WAY_W-1:0]      way_ff;
   logic [SET_W-1:0]      set_out_ff;
   logic [CNT_W-1:0]      hit_ff, miss_ff, evict_ff;

   // effective configuration with saturation of out-of-range values
   always_comb begin
      s_eff = (sbits_ff > SBITS_W'(MAX_SET_BITS)) ? SBITS_W'(MAX_SET_BITS) : sbits_ff;
      b_eff = (obits_ff > OBITS_W'(OFFSET_MAX)) ? OBITS_W'(OFFSET_MAX) : obits_ff;
      if (ebits_ff == '0) begin
         e_eff = WAYS_W'(1);
      end else if (ebits_ff > EBITS_W'(MAX_WAYS)) begin
         e_eff = WAYS_W'(MAX_WAYS);
      end else begin
         e_eff = WAYS_W'(ebits_ff);
      end
      smask        = ~({SET_W{1'b1}} << s_eff);
      addr_shifted = req_address >> b_eff;
      set_calc     = addr_shifted[SET_W-1:0] & smask;
      tag_calc     = addr_ff >> (SHIFT_W'(b_eff) + SHIFT_W'(s_eff));
   end

   sacl_ram #(.WIDTH(TAG_ROW_W), .DEPTH(NUM_SETS)) u_tag_ram (
      .clock (clock),
      .we    (cmd.update && !hit),
      .waddr (set_ff),
      .wdata (tag_wr),
      .re    (cmd.accept),
      .raddr (set_calc),
      .rdata (tag_rd)
   );

   sacl_ram #(.WIDTH(META_ROW_W), .DEPTH(NUM_SETS)) u_meta_ram (
      .clock (clock),
      .we    (cmd.update),
      .waddr (set_ff),
      .wdata (meta_wr),
      .re    (cmd.accept),
      .raddr (set_calc),
      .rdata (meta_rd)
   );

   // lookup: hit, cold way and victim over the ways in use
   always_comb begin
      hit       = 1'b0;
      cold      = 1'b0;
      vic_found = 1'b0;
      hit_way   = '0;
      cold_way  = '0;
      vic_way   = '0;
      hit_rank  = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         way_on[w]    = (WAYS_W'(w) < e_eff);
         way_valid[w] = rowv_ff[set_ff] && meta_rd[w];
         way_rank[w]  = rowv_ff[set_ff] ? meta_rd[MAX_WAYS + w*RANK_W +: RANK_W] : '0;
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (way_on[w]) begin
            if (way_valid[w] && tag_rd[w*TAG_W +: TAG_W] == tag_calc) begin
               hit      = 1'b1;
               hit_way  = WAY_W'(w);
               hit_rank = way_rank[w];
            end
            if (!way_valid[w]) begin
               cold     = 1'b1;
               cold_way = WAY_W'(w);
            end else if (!vic_found || way_rank[w] >= way_rank[vic_way]) begin
               vic_found = 1'b1;
               vic_way   = WAY_W'(w);
            end
         end
      end
      fill_way = cold ? cold_way : vic_way;
      way_sel  = hit ? hit_way : fill_way;
      if (hit) begin
         outcome = OUT_HIT;
         added   = (kind_ff == KIND_MODIFY) ? 2'd2 : 2'd1;
      end else begin
         outcome = cold ? OUT_FILL : OUT_EVICT;
         added   = (kind_ff == KIND_MODIFY) ? 2'd1 : 2'd0;
      end
   end

   // new row contents: age ranks, promote or fill the chosen way
   always_comb begin
      tag_wr  = tag_rd;
      meta_wr = '0;
      tag_wr[fill_way*TAG_W +: TAG_W] = tag_calc;
      for (int w = 0; w < MAX_WAYS; w++) begin
         logic [RANK_W-1:0] r;
         logic              age;
         r   = way_rank[w];
         age = 1'b0;
         if (way_on[w] && way_valid[w]) begin
            age = hit ? (r != '0 && r < hit_rank) : 1'b1;
         end
         if (age && r != RANK_MAX) begin
            r = r + 1'b1;
         end
         meta_wr[w]                             = way_valid[w];
         meta_wr[MAX_WAYS + w*RANK_W +: RANK_W] = r;
      end
      meta_wr[way_sel]                                   = 1'b1;
      meta_wr[MAX_WAYS + way_sel*RANK_W +: RANK_W]       = RANK_W'(1);
   end

   // saturating totals
   always_comb begin
      hit_sum   = {1'b0, hit_ff} + (CNT_W+1)'(added);
      miss_sum  = {1'b0, miss_ff} + (CNT_W+1)'(!hit);
      evict_sum = {1'b0, evict_ff} + (CNT_W+1)'(!hit && !cold);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sbits_ff  <= '0;
         obits_ff  <= '0;
         ebits_ff  <= EBITS_W'(1);
         rowv_ff   <= '0;
         hit_ff    <= '0;
         miss_ff   <= '0;
         evict_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.update;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_SET_BITS:    sbits_ff <= csr_wdata[SBITS_W-1:0];
               CSR_OFFSET_BITS: obits_ff <= csr_wdata[OBITS_W-1:0];
               CSR_WAYS:        ebits_ff <= csr_wdata[EBITS_W-1:0];
               default: ;
            endcase
         end
         if (cmd.update) begin
            rowv_ff[set_ff] <= 1'b1;
            hit_ff   <= hit_sum[CNT_W]   ? '1 : hit_sum[CNT_W-1:0];
            miss_ff  <= miss_sum[CNT_W]  ? '1 : miss_sum[CNT_W-1:0];
            evict_ff <= evict_sum[CNT_W] ? '1 : evict_sum[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff <= req_kind;
         addr_ff <= req_address;
         set_ff  <= set_calc;
      end
      if (cmd.update) begin
         outcome_ff <= outcome;
         added_ff   <= added;
         way_ff     <= way_sel;
         set_out_ff <= set_ff;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_outcome     = outcome_ff;
   assign rsp_hits_added  = added_ff;
   assign rsp_way_used    = 3'(way_ff);
   assign rsp_set_index   = 6'(set_out_ff);
   assign rsp_hit_total   = hit_ff;
   assign rsp_miss_total  = miss_ff;
   assign rsp_evict_total = evict_ff;

endmodule

### hdl/set_assoc_cache_lru_sim.sv
// Top level of the set-associative cache tag store with true-LRU replacement.
//
//   channel   ports                                   handshake
//   request   req_kind, req_address                   start high, busy low
//   response  rsp_outcome .. rsp_evict_total          rsp_strobe, one cycle
//   config    csr_index, csr_wdata                    csr_we
//
// The accept edge reads one set row from the tag and metadata RAMs; the update
// edge compares the ways in use, writes the row back (tags on a miss only)
// and registers the result. No word is taken in this RAM read-modify-write.
// A new word may be accepted in the cycle the result is shown.
// Reset is synchronous; a row-valid flop per set makes unwritten rows read as
// empty, so no clearing pass is needed. The receiver cannot stall.
module set_assoc_cache_lru_sim (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_kind,
   input  logic [sacl_pkg::TAG_W-1:0]      req_address,
   input  logic                            csr_we,
   input  logic [sacl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sacl_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                            rsp_strobe,
   output logic [1:0]                      rsp_outcome,
   output logic [1:0]                      rsp_hits_added,
   output logic [2:0]                      rsp_way_used,
   output logic [5:0]                      rsp_set_index,
   output logic [sacl_pkg::CNT_W-1:0]      rsp_hit_total,
   output logic [sacl_pkg::CNT_W-1:0]      rsp_miss_total,
   output logic [sacl_pkg::CNT_W-1:0]      rsp_evict_total
);
   import sacl_pkg::*;

   cmd_type cmd;

   // sequence accept and update
   sacl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // hold config, look up the set, age ranks and count
   sacl_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_kind        (req_kind),
      .req_address     (req_address),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_strobe      (rsp_strobe),
      .rsp_outcome     (rsp_outcome),
      .rsp_hits_added  (rsp_hits_added),
      .rsp_way_used    (rsp_way_used),
      .rsp_set_index   (rsp_set_index),
      .rsp_hit_total   (rsp_hit_total),
      .rsp_miss_total  (rsp_miss_total),
      .rsp_evict_total (rsp_evict_total)
   );

endmodule

### hdl/sacl_checker.sv
// Port-level assertions for the cache tag store, bound to the top level.
module sacl_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_strobe,
   input logic [1:0]                      rsp_outcome,
   input logic [1:0]                      rsp_hits_added,
   input logic [sacl_pkg::CNT_W-1:0]      rsp_evict_total,
   input logic [sacl_pkg::CNT_W-1:0]      rsp_miss_total
);
   import sacl_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted word did not raise busy");

   a_busy_result: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_strobe && !busy) else $error("update gave no result");

   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("results back to back");

   a_hit_adds: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_outcome == OUT_HIT |-> rsp_hits_added != 2'd0)
      else $error("hit added no hits");

   a_evict_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_outcome == OUT_EVICT |-> rsp_evict_total != '0 &&
      rsp_miss_total != '0) else $error("eviction not counted");

endmodule

bind set_assoc_cache_lru_sim sacl_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_outcome     (rsp_outcome),
   .rsp_hits_added  (rsp_hits_added),
   .rsp_evict_total (rsp_evict_total),
   .rsp_miss_total  (rsp_miss_total)
);
